[src/cdq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 128;

  localparam logic [3:0] K_PUSH_FRONT = 4'd0;
  localparam logic [3:0] K_PUSH_BACK  = 4'd1;
  localparam logic [3:0] K_POP_FRONT  = 4'd2;
  localparam logic [3:0] K_POP_BACK   = 4'd3;
  localparam logic [3:0] K_READ_FRONT = 4'd4;
  localparam logic [3:0] K_READ_BACK  = 4'd5;
  localparam logic [3:0] K_CLEAR      = 4'd6;
  localparam logic [3:0] K_REVERSE    = 4'd7;
  localparam logic [3:0] K_SORT       = 4'd8;
  localparam logic [3:0] K_STATUS     = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVFL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               read_valid;
    logic [1:0]         status;
    logic [7:0]         count;
    logic               is_empty;
  } out_beat_t;

  // Row-wide command to every cell.
  typedef enum logic [2:0] {
    C_HOLD, C_SHR, C_SHL, C_LOADF, C_LOADB, C_ODD, C_EVEN
  } cell_op_t;

  // swap_all: odd/even phase swaps every in-range pair (reverse walk).
  typedef struct packed {
    cell_op_t           op;
    logic               swap_all;
    logic signed [31:0] word;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/circular_deque_with_reverse_sort.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_with_reverse_sort
// Deque of signed words kept front-aligned in a row of DEPTH cells.
// ----------------------------------------------------------------------------
// Push, pop, read, clear and status pass through S_EXEC and S_DONE before out_valid.
// Reverse and sort walk the cell row in alternating odd/even neighbor phases,
// one phase per held word (at least one), then go to S_DONE. Reverse swaps
// every in-range pair, sort only the out-of-order ones.
// busy is high from accept until the cycle before the result beat, and a new
// beat can be taken at the edge that takes the result; out_valid is a
// single-cycle strobe and must be taken when shown.
module circular_deque_with_reverse_sort
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_beat_t  in_beat,
  output logic           out_valid,
  output out_beat_t      out_beat
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SORT, S_DONE} state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      step_r;
  logic [3:0]         kind_r;
  logic signed [31:0] val_r;
  logic               out_valid_r;
  out_beat_t          out_r;
  cell_ctl_t          ctl;
  logic signed [31:0] words [DEPTH];
  logic               full;
  logic               emp;

  assign full = (cnt_r == CW'(DEPTH));
  assign emp  = (cnt_r == '0);
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  always_comb begin
    ctl.op       = C_HOLD;
    ctl.swap_all = 1'b0;
    ctl.word     = val_r;
    if (state_r == S_EXEC) begin
      case (kind_r)
        K_PUSH_FRONT: if (!full) ctl.op = C_SHR;
        K_PUSH_BACK:  if (!full) ctl.op = C_LOADB;
        K_POP_FRONT:  if (!emp) ctl.op = C_SHL;
        default:      ctl.op = C_HOLD;
      endcase
    end else if (state_r == S_SORT) begin
      ctl.op       = step_r[0] ? C_ODD : C_EVEN;
      ctl.swap_all = (kind_r == K_REVERSE);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t          c;
    logic signed [31:0] lw;
    logic signed [31:0] rw;
    logic               lo_ok;
    logic               hi_ok;
    logic               here;
    if (i == 0) begin : g_l
      assign lw = val_r;
    end else begin : g_l
      assign lw = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_r
      assign rw = words[i];
    end else begin : g_r
      assign rw = words[i+1];
    end
    assign here  = ((CW+1)'(i) < {1'b0, cnt_r});
    assign lo_ok = (i > 0);
    assign hi_ok = ((CW+1)'(i + 1) < {1'b0, cnt_r});
    always_comb begin
      c = ctl;
      if (ctl.op == C_LOADB) c.op = ((CW+1)'(i) == {1'b0, cnt_r}) ? C_LOADF : C_HOLD;
    end
    cdq_cell u_cell (
      .clk         (clk),
      .ctl         (c),
      .odd_pos     (1'(i % 2)),
      .in_range    (here),
      .lo_in_range (lo_ok),
      .hi_in_range (hi_ok),
      .left        (lw),
      .right       (rw),
      .word        (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (start) begin
          kind_r  <= in_beat.kind;
          val_r   <= in_beat.value;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          out_r.read_value <= '0;
          out_r.read_valid <= 1'b0;
          out_r.status     <= ST_OK;
          state_r          <= S_DONE;
          case (kind_r)
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (full) out_r.status <= ST_OVFL;
              else cnt_r <= cnt_r + 1'b1;
            end
            K_POP_FRONT, K_POP_BACK, K_READ_FRONT, K_READ_BACK: begin
              if (emp) begin
                out_r.status <= ST_EMPTY;
              end else begin
                out_r.read_valid <= 1'b1;
                out_r.read_value <= (kind_r == K_POP_FRONT || kind_r == K_READ_FRONT)
                                    ? words[0] : words[AW'(cnt_r - 1'b1)];
                if (kind_r == K_POP_FRONT || kind_r == K_POP_BACK) cnt_r <= cnt_r - 1'b1;
              end
            end
            K_CLEAR: cnt_r <= '0;
            K_REVERSE, K_SORT: begin
              step_r  <= '0;
              state_r <= S_SORT;
            end
            default: ;
          endcase
        end
        S_SORT: begin
          step_r <= step_r + 1'b1;
          if (step_r + CW'(1) >= cnt_r) state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r    <= 1'b1;
          out_r.count    <= 8'(cnt_r);
          out_r.is_empty <= (cnt_r == '0);
          state_r        <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/cdq_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the row: shifts, loads or swaps with its neighbors.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic               odd_pos,
  input  wire logic               in_range,
  input  wire logic               lo_in_range,
  input  wire logic               hi_in_range,
  input  wire logic signed [31:0] left,
  input  wire logic signed [31:0] right,
  output logic signed [31:0]      word
);

  logic signed [31:0] word_r;
  logic signed [31:0] word_nxt;
  logic               pair_lo_odd;
  logic               pair_lo_even;

  assign word = word_r;
  assign pair_lo_odd  = odd_pos;
  assign pair_lo_even = !odd_pos;

  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      C_SHR:   word_nxt = left;
      C_SHL:   word_nxt = right;
      C_LOADF: word_nxt = ctl.word;
      C_LOADB: word_nxt = ctl.word;
      C_ODD, C_EVEN: begin
        if ((ctl.op == C_ODD) ? pair_lo_odd : pair_lo_even) begin
          if (in_range && hi_in_range && (ctl.swap_all || word_r > right)) word_nxt = right;
        end else begin
          if (in_range && lo_in_range && (ctl.swap_all || left > word_r)) word_nxt = left;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

`default_nettype wire

[src/cdq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the deque handshake and result beats.
// ----------------------------------------------------------------------------
module cdq_checker
  import cdq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input out_beat_t out_beat
);

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept without busy");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_beat.is_empty == (out_beat.count == 8'd0)))
    else $error("empty flag mismatch");

  a_rv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.read_valid) |-> (out_beat.status == ST_OK))
    else $error("read with error status");

endmodule

bind circular_deque_with_reverse_sort cdq_checker u_cdq_checker (.*);
